// ===== src/positional_array_list_macros.svh =====
// ----------------------------------------------------------------------------
// Positional array list assertion macros
// Shared concurrent assertion forms for the list controller and datapath.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_LIST_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PAL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("positional array list assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PAL_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("positional array list assertion failed");

`endif

// ===== src/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// Positional array list package
// Sizes, action and status codes, and the command and status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package pal_pkg;

   localparam int CAPACITY = 128;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = 8;
   localparam int POS_W    = 8;
   localparam int VAL_W    = 32;

   localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

   typedef logic [1:0]              action_type;
   typedef logic [1:0]              status_type;
   typedef logic [ADDR_W-1:0]       addr_type;
   typedef logic [CNT_W-1:0]        count_type;
   typedef logic [POS_W-1:0]        pos_type;
   typedef logic signed [VAL_W-1:0] word_type;

   localparam action_type ACT_INSERT = 2'd0;
   localparam action_type ACT_REMOVE = 2'd1;
   localparam action_type ACT_MODIFY = 2'd2;
   localparam action_type ACT_READ   = 2'd3;

   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_FULL   = 2'd1;
   localparam status_type ST_EMPTY  = 2'd2;
   localparam status_type ST_BADPOS = 2'd3;

   localparam word_type READ_FAIL = -32'sd1;

   // Controller to datapath.
   typedef struct packed {
      logic capture;
      logic check;
      logic move;
      logic finish;
      logic load;
   } pal_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic need_move;
      logic last_move;
   } pal_stat_type;

endpackage

// ===== src/pal_req_if.sv =====
// ----------------------------------------------------------------------------
// Positional array list request channel
// Valid/ready channel carrying one list request item.
// ----------------------------------------------------------------------------
interface pal_req_if;

   logic                 valid;
   logic                 ready;
   pal_pkg::action_type  action;
   pal_pkg::pos_type     position;
   pal_pkg::word_type    value;

   modport source (output valid, output action, output position, output value,
                   input ready);
   modport sink   (input valid, input action, input position, input value,
                   output ready);

endinterface

// ===== src/pal_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Positional array list response channel
// Valid/ready channel carrying one list response item.
// ----------------------------------------------------------------------------
interface pal_rsp_if;

   logic                 valid;
   logic                 ready;
   pal_pkg::status_type  status;
   pal_pkg::word_type    read_data;
   pal_pkg::count_type   entry_count;
   logic                 is_empty;
   logic                 is_full;

   modport source (output valid, output status, output read_data,
                   output entry_count, output is_empty, output is_full,
                   input ready);
   modport sink   (input valid, input status, input read_data,
                   input entry_count, input is_empty, input is_full,
                   output ready);

endinterface

// ===== src/positional_array_list.sv =====
// ----------------------------------------------------------------------------
// Positional array list
// Bounded ordered list of signed words addressed by 1-based position, with
// insert, remove, modify and read requests and one response per request.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake     Payload
//  req_chan  in   valid/ready   action, position, value
//  rsp_chan  out  valid/ready   status, read_data, entry_count, is_empty, is_full
//
// A request that moves no entries goes from accept through CHECK and DONE back to IDLE.
// Insert and remove that shift entries also pass through MOVE and FINISH, where
// the entry memory, with a single write port, moves one entry per cycle.
// Reset clears the count only; entries are undefined until written.
// A result waiting in the response register does not block the next accept;
// the following result waits until the response register is taken.
// ----------------------------------------------------------------------------
module positional_array_list (
   input  logic     clock,
   input  logic     reset,
   pal_req_if.sink  req_chan,
   pal_rsp_if.source rsp_chan
);

   pal_pkg::pal_cmd_type  cmd;
   pal_pkg::pal_stat_type stat;

   pal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   pal_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_action      (req_chan.action),
      .req_position    (req_chan.position),
      .req_value       (req_chan.value),
      .rsp_status      (rsp_chan.status),
      .rsp_read_data   (rsp_chan.read_data),
      .rsp_entry_count (rsp_chan.entry_count),
      .rsp_is_empty    (rsp_chan.is_empty),
      .rsp_is_full     (rsp_chan.is_full)
   );

endmodule

// ===== src/pal_ctrl.sv =====
// ----------------------------------------------------------------------------
// Positional array list controller
// Sequences each request through check, any shift and finish, and response load,
// and owns the request ready and response valid handshakes.
// ----------------------------------------------------------------------------
`include "positional_array_list_macros.svh"

module pal_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pal_pkg::pal_cmd_type  cmd,
   input  pal_pkg::pal_stat_type stat
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_MOVE   = 3'd2;
   localparam logic [2:0] S_FINISH = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       out_valid_ff, out_valid_in;
   logic       load;

   // The response register is free when empty or being drained this cycle.
   assign load = (state_ff == S_DONE) && (!out_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = stat.need_move ? S_MOVE : S_DONE;
         end
         S_MOVE: begin
            if (stat.last_move) state_in = S_FINISH;
         end
         S_FINISH: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (load) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = out_valid_ff;

   assign cmd = '{capture: (state_ff == S_IDLE) && req_valid,
                  check:   (state_ff == S_CHECK),
                  move:    (state_ff == S_MOVE),
                  finish:  (state_ff == S_FINISH),
                  load:    load};

   `PAL_ASSERT_NXT(a_accept_to_check, clock, reset, req_valid && req_ready, state_ff == S_CHECK)
   `PAL_ASSERT_NXT(a_last_finish, clock, reset, cmd.move && stat.last_move, state_ff == S_FINISH)
   `PAL_ASSERT_NXT(a_load_sets_valid, clock, reset, load, out_valid_ff && (state_ff == S_IDLE))

endmodule

// ===== src/pal_dp.sv =====
// ----------------------------------------------------------------------------
// Positional array list datapath
// Holds the entry memory, the count and the captured request, checks the
// request, shifts entries one per cycle and builds the response item.
// ----------------------------------------------------------------------------
`include "positional_array_list_macros.svh"

module pal_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  pal_pkg::pal_cmd_type   cmd,
   output pal_pkg::pal_stat_type  stat,
   input  pal_pkg::action_type    req_action,
   input  pal_pkg::pos_type       req_position,
   input  pal_pkg::word_type      req_value,
   output pal_pkg::status_type    rsp_status,
   output pal_pkg::word_type      rsp_read_data,
   output pal_pkg::count_type     rsp_entry_count,
   output logic                   rsp_is_empty,
   output logic                   rsp_is_full
);

   localparam int EXT_W = pal_pkg::CNT_W + 1;

   pal_pkg::word_type   entries_ff [pal_pkg::CAPACITY];
   pal_pkg::word_type   rdq_ff;

   pal_pkg::action_type act_ff, act_in;
   pal_pkg::pos_type    pos_ff, pos_in;
   pal_pkg::word_type   val_ff, val_in;
   pal_pkg::status_type status_ff, status_in;
   pal_pkg::addr_type   dst_ff, dst_in;
   pal_pkg::count_type  count_ff, count_in;

   pal_pkg::status_type rsp_status_ff, rsp_status_in;
   pal_pkg::word_type   rsp_rdata_ff, rsp_rdata_in;
   pal_pkg::count_type  rsp_count_ff, rsp_count_in;
   logic                rsp_empty_ff, rsp_empty_in;
   logic                rsp_full_ff, rsp_full_in;

   pal_pkg::status_type chk_status;
   logic                ok;
   logic                is_insert;
   logic                is_append;
   logic                is_tail;
   logic                pos_bad_rd;
   logic                pos_bad_ins;
   logic                need_move;
   logic                last_move;
   logic                finish_ins;
   logic [EXT_W-1:0]    pos_ext;
   logic [EXT_W-1:0]    cnt_ext;
   logic [EXT_W-1:0]    dst_ext;
   pal_pkg::addr_type   pos_idx;

   logic                wr_en;
   pal_pkg::addr_type   wr_addr;
   pal_pkg::word_type   wr_data;
   logic                rd_en;
   pal_pkg::addr_type   rd_addr;

   assign pos_ext   = EXT_W'(pos_ff);
   assign cnt_ext   = EXT_W'(count_ff);
   assign dst_ext   = EXT_W'(dst_ff);
   assign pos_idx   = pal_pkg::ADDR_W'(pos_ff - 8'd1);
   assign is_insert = (act_ff == pal_pkg::ACT_INSERT);

   assign pos_bad_rd  = (pos_ff == '0) || (pos_ext > cnt_ext);
   assign pos_bad_ins = (pos_ff == '0) || (pos_ext > cnt_ext + EXT_W'(1));
   assign is_append   = (pos_ext == cnt_ext + EXT_W'(1));
   assign is_tail     = (pos_ff == count_ff);

   // Full is tested before the position on insert, empty before it on remove.
   always_comb begin
      chk_status = pal_pkg::ST_OK;
      case (act_ff) inside
         pal_pkg::ACT_INSERT: begin
            if (count_ff >= pal_pkg::CAP_COUNT) chk_status = pal_pkg::ST_FULL;
            else if (pos_bad_ins)               chk_status = pal_pkg::ST_BADPOS;
         end
         pal_pkg::ACT_REMOVE: begin
            if (count_ff == '0)  chk_status = pal_pkg::ST_EMPTY;
            else if (pos_bad_rd) chk_status = pal_pkg::ST_BADPOS;
         end
         pal_pkg::ACT_MODIFY, pal_pkg::ACT_READ: begin
            if (pos_bad_rd) chk_status = pal_pkg::ST_BADPOS;
         end
         default: begin
            chk_status = pal_pkg::ST_BADPOS;
         end
      endcase
   end

   assign ok        = (chk_status == pal_pkg::ST_OK);
   assign need_move = ok && ((is_insert && !is_append) ||
                             ((act_ff == pal_pkg::ACT_REMOVE) && !is_tail));
   // Insert walks down to index pos, just above the target slot; remove walks up to count-2.
   assign last_move = is_insert ? (dst_ext == pos_ext)
                                : (dst_ext + EXT_W'(2) == cnt_ext);

   assign stat = '{need_move: need_move, last_move: last_move};

   assign finish_ins = cmd.finish && is_insert;

   // Single write port.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_idx;
      wr_data = val_ff;
      if (cmd.check && ok &&
          ((act_ff == pal_pkg::ACT_MODIFY) || (is_insert && !need_move))) begin
         wr_en = 1'b1;
      end else if (cmd.move) begin
         wr_en   = 1'b1;
         wr_addr = dst_ff;
         wr_data = rdq_ff;
      end else if (cmd.finish && is_insert) begin
         wr_en = 1'b1;
      end
   end

   // Single read port; the word read lands in rdq_ff for the next move write or the response load.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = pos_idx;
      if (cmd.check && ok && (act_ff == pal_pkg::ACT_READ)) begin
         rd_en = 1'b1;
      end else if (cmd.check && need_move) begin
         rd_en   = 1'b1;
         rd_addr = is_insert ? pal_pkg::ADDR_W'(count_ff - 8'd1)
                             : pal_pkg::ADDR_W'(pos_ff);
      end else if (cmd.move && !last_move) begin
         rd_en   = 1'b1;
         rd_addr = is_insert ? (dst_ff - pal_pkg::ADDR_W'(2))
                             : (dst_ff + pal_pkg::ADDR_W'(2));
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) entries_ff[wr_addr] <= wr_data;
      if (rd_en) rdq_ff <= entries_ff[rd_addr];
   end

   always_comb begin
      act_in    = act_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      status_in = status_ff;
      dst_in    = dst_ff;
      count_in  = count_ff;
      if (cmd.capture) begin
         act_in = req_action;
         pos_in = req_position;
         val_in = req_value;
      end
      if (cmd.check) begin
         status_in = chk_status;
         dst_in    = is_insert ? pal_pkg::ADDR_W'(count_ff) : pos_idx;
         if (ok && !need_move) begin
            if (is_insert)                             count_in = count_ff + 8'd1;
            else if (act_ff == pal_pkg::ACT_REMOVE)    count_in = count_ff - 8'd1;
         end
      end
      if (cmd.move) begin
         dst_in = is_insert ? (dst_ff - pal_pkg::ADDR_W'(1))
                            : (dst_ff + pal_pkg::ADDR_W'(1));
      end
      if (cmd.finish) begin
         count_in = is_insert ? (count_ff + 8'd1) : (count_ff - 8'd1);
      end
   end

   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_rdata_in  = rsp_rdata_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_full_in   = rsp_full_ff;
      if (cmd.load) begin
         rsp_status_in = status_ff;
         if (act_ff == pal_pkg::ACT_READ) begin
            rsp_rdata_in = (status_ff == pal_pkg::ST_OK) ? rdq_ff : pal_pkg::READ_FAIL;
         end else begin
            rsp_rdata_in = '0;
         end
         rsp_count_in = count_ff;
         rsp_empty_in = (count_ff == '0);
         rsp_full_in  = (count_ff == pal_pkg::CAP_COUNT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      dst_ff        <= dst_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rdata_ff  <= rsp_rdata_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_full_ff   <= rsp_full_in;
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_read_data   = rsp_rdata_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_is_full     = rsp_full_ff;

   `PAL_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= pal_pkg::CAP_COUNT)
   `PAL_ASSERT_IMP(a_move_in_range, clock, reset, cmd.move, dst_ext <= cnt_ext)
   `PAL_ASSERT_NXT(a_insert_grows, clock, reset, finish_ins, count_ff == $past(count_ff) + 8'd1)

endmodule
